[rtl/itr_pkg.sv]
// Shared constants, types and helper functions for the radix digit converter.
`timescale 1ns / 1ps

package itr_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 32;

    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 7;
    localparam int DIV_BITS = 4;

    localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int ADDR_W    = $clog2(MAX_DIGITS);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A     = CHAR_W'(65);
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_rd;
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic quot_zero;
        logic count_full;
        logic idx_zero;
    } status_t;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] rdx);
        logic [RADIX_W-1:0] r;
        r = rdx;
        if (rdx < RADIX_MIN)
        begin
            r = RADIX_MIN;
        end
        else if (rdx > RADIX_MAX)
        begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    // Restoring division of one chunk: returns {quotient bits, remainder}
    function automatic logic [DIV_BITS+DIGIT_W-1:0] div_chunk(
        input logic [DIGIT_W-1:0]  rem,
        input logic [DIV_BITS-1:0] chunk,
        input logic [RADIX_W-1:0]  rdx
    );
        logic [DIGIT_W:0]    trial;
        logic [DIGIT_W-1:0]  r;
        logic [DIV_BITS-1:0] q;
        r = rem;
        q = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            trial = {r, chunk[i]};
            if (trial >= rdx)
            begin
                trial = trial - rdx;
                q[i]  = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        return {q, r};
    endfunction

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE)
        begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(DIGIT_NINE) - CHAR_W'(1);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[rtl/itr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module itr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/itr_datapath.sv]
// Datapath: radix register, chunked divider, digit store and output stage.
`timescale 1ns / 1ps

module itr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  itr_pkg::cmd_t                     cmd,
    output itr_pkg::status_t                  status,
    input  logic [itr_pkg::VALUE_WIDTH-1:0]   value,
    input  logic                              cfg_we,
    input  logic [itr_pkg::RADIX_W-1:0]       cfg_data,
    output logic                              digit_valid,
    output logic [itr_pkg::CHAR_W-1:0]        digit_char,
    output logic                              last_digit
);

    logic [itr_pkg::RADIX_W-1:0]  radix_reg;
    logic [itr_pkg::DIV_W-1:0]    div_reg,    div_next;
    logic [itr_pkg::DIGIT_W-1:0]  rem_reg,    rem_next;
    logic [itr_pkg::STEP_W-1:0]   step_reg,   step_next;
    logic [itr_pkg::ADDR_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [itr_pkg::ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                         valid_reg,  valid_next;
    logic                         last_reg,   last_next;

    logic [itr_pkg::RADIX_W-1:0]                  eff_radix;
    logic [itr_pkg::DIV_BITS+itr_pkg::DIGIT_W-1:0] chunk_res;
    logic [itr_pkg::DIV_W-1:0]                    div_shift;
    logic                                         ram_we;
    logic [itr_pkg::DIGIT_W-1:0]                  ram_rdata;

    assign eff_radix = itr_pkg::sat_radix(radix_reg);
    assign chunk_res = itr_pkg::div_chunk(rem_reg,
                                          div_reg[itr_pkg::DIV_W-1 -: itr_pkg::DIV_BITS],
                                          eff_radix);
    assign div_shift = {div_reg[itr_pkg::DIV_W-itr_pkg::DIV_BITS-1:0],
                        chunk_res[itr_pkg::DIV_BITS+itr_pkg::DIGIT_W-1:itr_pkg::DIGIT_W]};

    assign status.step_last  = (step_reg == itr_pkg::STEP_W'(itr_pkg::DIV_STEPS - 1));
    assign status.quot_zero  = (div_shift == '0);
    assign status.count_full = (wr_idx_reg == itr_pkg::ADDR_W'(itr_pkg::MAX_DIGITS - 1));
    assign status.idx_zero   = (rd_idx_reg == '0);

    assign ram_we = cmd.div_step && status.step_last;

    always_comb
    begin
        div_next    = div_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
        begin
            div_next    = itr_pkg::DIV_W'(value);
            rem_next    = '0;
            step_next   = '0;
            wr_idx_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_next = div_shift;
            if (status.step_last)
            begin
                rem_next    = '0;
                step_next   = '0;
                wr_idx_next = wr_idx_reg + itr_pkg::ADDR_W'(1);
                rd_idx_next = wr_idx_reg;
            end
            else
            begin
                rem_next  = chunk_res[itr_pkg::DIGIT_W-1:0];
                step_next = step_reg + itr_pkg::STEP_W'(1);
            end
        end
        else if (cmd.emit_rd)
        begin
            rd_idx_next = rd_idx_reg - itr_pkg::ADDR_W'(1);
        end
        valid_next = cmd.emit_rd;
        last_next  = cmd.emit_rd && status.idx_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= itr_pkg::RADIX_RESET;
            step_reg   <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_data;
            end
            step_reg   <= step_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    itr_ram #(
        .WIDTH (itr_pkg::DIGIT_W),
        .DEPTH (itr_pkg::MAX_DIGITS)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (chunk_res[itr_pkg::DIGIT_W-1:0]),
        .re    (cmd.emit_rd),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign digit_valid = valid_reg;
    assign last_digit  = last_reg;
    assign digit_char  = itr_pkg::to_ascii(ram_rdata);

endmodule

[rtl/itr_ctrl.sv]
// Controller: sequences load, digit division and digit readout.
`timescale 1ns / 1ps

module itr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  itr_pkg::status_t status,
    output itr_pkg::cmd_t    cmd,
    output logic             busy
);

    itr_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = itr_pkg::ST_DIV;
                end
            end
            itr_pkg::ST_DIV:
            begin
                if (status.step_last && (status.quot_zero || status.count_full))
                begin
                    state_next = itr_pkg::ST_EMIT;
                end
            end
            itr_pkg::ST_EMIT:
            begin
                if (status.idx_zero)
                begin
                    state_next = itr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            itr_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            itr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            itr_pkg::ST_EMIT:
            begin
                cmd.emit_rd = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/integer_to_radix_digits.sv]
// Top level: integer to ASCII digit converter in a configurable radix.
// Each digit comes from the 4-bit-per-cycle divider stepping through all DIV_STEPS chunks;
// the digits are then read out of the store, most significant first, and stream out at
// one digit per cycle, the last one flagged by last_digit. A request yields D digits
// (D = 1..31); the shared divider serves one request at a time, taken only while idle.
// Reset sets radix to 10 and idles the controller; the digit store is not cleared.
`timescale 1ns / 1ps

module integer_to_radix_digits (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [itr_pkg::VALUE_WIDTH-1:0] value,
    input  logic                            cfg_we,
    input  logic [itr_pkg::RADIX_W-1:0]     cfg_data,
    output logic                            digit_valid,
    output logic [itr_pkg::CHAR_W-1:0]      digit_char,
    output logic                            last_digit
);

    itr_pkg::cmd_t    cmd;
    itr_pkg::status_t status;

    itr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but controller not busy");

    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last_digit |-> digit_valid)
        else $error("last digit flag without strobe");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !last_digit |=> digit_valid)
        else $error("digit run broken before last digit");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> digit_valid && last_digit)
        else $error("controller idled without delivering last digit");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.emit_rd}))
        else $error("conflicting datapath commands");

endmodule
